// File: hdl/assert_macros.svh
// assertion helper macros for the grid radius search rtl
// no dependencies; included by grs_queue and grs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hdl/grs_pkg.sv
// shared types and constants for the grid radius feature search
// no dependencies
`default_nettype none
package grs_pkg;
   localparam int GRID_COLUMNS_DEF  = 64;
   localparam int GRID_ROWS_DEF     = 48;
   localparam int MAX_FEATURES_DEF  = 1024;
   localparam int CELL_CAPACITY_DEF = 8;
   localparam int MAX_HITS_DEF      = 64;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [2:0] KIND_LOADED  = 3'd0;
   localparam logic [2:0] KIND_DROPPED = 3'd1;
   localparam logic [2:0] KIND_CLEARED = 3'd2;
   localparam logic [2:0] KIND_HIT     = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;

   localparam logic [1:0] REG_MIN_X = 2'd0;
   localparam logic [1:0] REG_MIN_Y = 2'd1;
   localparam logic [1:0] REG_INV_W = 2'd2;
   localparam logic [1:0] REG_INV_H = 2'd3;

   // one classified command from the front end
   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  feature_index;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [5:0]  cell_col;
      logic [5:0]  cell_row;
      logic [15:0] radius;
      logic        load_ok;
      logic        span_ok;
      logic [7:0]  cx0;
      logic [7:0]  cx1;
      logic [7:0]  cy0;
      logic [7:0]  cy1;
   } cmd_type;
endpackage
`default_nettype wire

// File: hdl/grs_front.sv
// front end: accepts commands, computes query cell spans in registered steps
// depends on grs_pkg
`default_nettype none
module grs_front import grs_pkg::*; #(
   parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
   parameter int GRID_ROWS    = GRID_ROWS_DEF,
   parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [9:0]  req_feature_index,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic [5:0]  req_cell_col,
   input  wire logic [5:0]  req_cell_row,
   input  wire logic [15:0] req_radius,
   input  wire logic [15:0] min_x,
   input  wire logic [15:0] min_y,
   input  wire logic [19:0] inv_w,
   input  wire logic [19:0] inv_h,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_full
);
   typedef enum logic [2:0] {F_IDLE, F_MX, F_MY, F_EDGE, F_PUSH} fstate_type;

   fstate_type   state_ff;
   cmd_type      cmd_ff;
   logic signed [17:0] dlo_ff, dhi_ff;
   logic [19:0]  inv_ff;
   logic signed [38:0] plo_ff, phi_ff;
   logic signed [38:0] xlo_ff, xhi_ff;

   logic signed [17:0] bx, by;
   logic signed [38:0] plo_in, phi_in;
   logic signed [18:0] flo, fhi;
   logic signed [18:0] fxlo, fxhi;
   logic               xok, yok;
   logic [7:0]         xa, xb, ya, yb;

   assign busy = (state_ff != F_IDLE);
   assign cmd_valid = (state_ff == F_PUSH);
   assign cmd = cmd_ff;

   assign bx = $signed({2'b0, req_pos_x}) - $signed({2'b0, min_x});
   assign by = $signed({2'b0, cmd_ff.pos_y}) - $signed({2'b0, min_y});
   // one registered multiply per edge
   assign plo_in = dlo_ff * $signed({1'b0, inv_ff});
   assign phi_in = dhi_ff * $signed({1'b0, inv_ff});
   // floor and ceil of q.20 products
   assign flo  = 19'(plo_ff >>> 20);
   assign fhi  = 19'((phi_ff + 39'sd1048575) >>> 20);
   assign fxlo = 19'(xlo_ff >>> 20);
   assign fxhi = 19'((xhi_ff + 39'sd1048575) >>> 20);

   always_comb begin
      xok = (fxlo < 19'(GRID_COLUMNS)) && (fxhi >= 0);
      yok = (flo < 19'(GRID_ROWS)) && (fhi >= 0);
      xa = (fxlo < 0) ? 8'd0 : 8'(fxlo);
      xb = (fxhi > 19'(GRID_COLUMNS - 1)) ? 8'(GRID_COLUMNS - 1) : 8'(fxhi);
      ya = (flo < 0) ? 8'd0 : 8'(flo);
      yb = (fhi > 19'(GRID_ROWS - 1)) ? 8'(GRID_ROWS - 1) : 8'(fhi);
   end

   // sequencer: capture, x products, y products, edges, enqueue (clear and load go straight to enqueue)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  cmd_ff.action        <= req_action;
                  cmd_ff.feature_index <= req_feature_index;
                  cmd_ff.pos_x         <= req_pos_x;
                  cmd_ff.pos_y         <= req_pos_y;
                  cmd_ff.cell_col      <= req_cell_col;
                  cmd_ff.cell_row      <= req_cell_row;
                  cmd_ff.radius        <= req_radius;
                  cmd_ff.load_ok <= (32'(req_feature_index) < MAX_FEATURES) &&
                                    (32'(req_cell_col) < GRID_COLUMNS) &&
                                    (32'(req_cell_row) < GRID_ROWS);
                  dlo_ff <= bx - $signed({2'b0, req_radius});
                  dhi_ff <= bx + $signed({2'b0, req_radius});
                  inv_ff <= inv_w;
                  if (req_action == ACT_QUERY) state_ff <= F_MX;
                  else if (req_action == ACT_CLEAR || req_action == ACT_LOAD)
                     state_ff <= F_PUSH;
               end
            end
            F_MX: begin
               xlo_ff <= plo_in;
               xhi_ff <= phi_in;
               dlo_ff <= by - $signed({2'b0, cmd_ff.radius});
               dhi_ff <= by + $signed({2'b0, cmd_ff.radius});
               inv_ff <= inv_h;
               state_ff <= F_MY;
            end
            F_MY: begin
               plo_ff <= plo_in;
               phi_ff <= phi_in;
               state_ff <= F_EDGE;
            end
            F_EDGE: begin
               cmd_ff.span_ok <= xok && yok;
               cmd_ff.cx0 <= xa;
               cmd_ff.cx1 <= xb;
               cmd_ff.cy0 <= ya;
               cmd_ff.cy1 <= yb;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!cmd_full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hdl/grs_queue.sv
// short command queue between front and back ends
// depends on grs_pkg
`default_nettype none
`include "assert_macros.svh"
module grs_queue import grs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_data,
   output logic      full,
   output logic      empty,
   input  wire logic pop,
   output cmd_type   pop_data
);
   cmd_type    mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, rd_ff;
   logic       do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];
   assign count_in = count_ff + 2'(do_push) - 2'(do_pop);

   // two entry ring
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   `ASSERT_IMPL(a_no_over, clock, reset, (count_ff <= 2'd2))
   `ASSERT_IMPL(a_ptr, clock, reset, ((count_ff == 2'd1) == (wr_ff != rd_ff)))
   `ASSERT_IMPL(a_push_grow, clock, reset, (do_push && !do_pop |=> !empty))
endmodule
`default_nettype wire

// File: hdl/grs_back.sv
// back end: grid stores, load, clear sweep and query scan with hit output
// depends on grs_pkg
`default_nettype none
`include "assert_macros.svh"
module grs_back import grs_pkg::*; #(
   parameter int GRID_COLUMNS  = GRID_COLUMNS_DEF,
   parameter int GRID_ROWS     = GRID_ROWS_DEF,
   parameter int MAX_FEATURES  = MAX_FEATURES_DEF,
   parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
   parameter int MAX_HITS      = MAX_HITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  cmd_ready,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       idle,
   output logic       rsp_valid,
   output logic [2:0] rsp_kind,
   output logic [9:0] rsp_hit_index,
   output logic       rsp_last,
   output logic       rsp_truncated
);
   localparam int NCELL = GRID_COLUMNS * GRID_ROWS;
   localparam int CW = $clog2(NCELL);
   localparam int SW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int FW = $clog2(MAX_FEATURES);
   localparam int MW = $clog2(NCELL * CELL_CAPACITY);
   localparam int HW = $clog2(MAX_HITS + 1);

   typedef enum logic [3:0] {
      B_INIT, B_IDLE, B_CMD, B_LOADRD, B_LOADWR, B_CLEAR,
      B_CELLRD, B_CELL, B_MEMRD, B_FEAT, B_TEST, B_NEXT, B_DONE
   } bstate_type;

   // memories
   logic [15:0]   fx_mem [MAX_FEATURES];
   logic [15:0]   fy_mem [MAX_FEATURES];
   logic [3:0]    fill_mem [NCELL];
   logic [9:0]    memb_mem [NCELL * CELL_CAPACITY];

   bstate_type    state_ff;
   cmd_type       c_ff;
   logic [CW-1:0] sweep_ff;
   logic [7:0]    ix_ff, iy_ff;
   logic [3:0]    n_ff, fill_rd_ff;
   logic [SW:0]   j_ff;
   logic [9:0]    memb_rd_ff, f_ff;
   logic [15:0]   fx_rd_ff, fy_rd_ff;
   logic [HW-1:0] emitted_ff;
   logic          over_ff, pend_ff;
   logic [9:0]    pend_idx_ff;
   logic          out_v_ff, out_last_ff, out_tr_ff;
   logic [2:0]    out_kind_ff;
   logic [9:0]    out_idx_ff;

   logic [CW-1:0] cell_cur, cell_load;
   logic [MW-1:0] memb_addr;
   logic [15:0]   dx, dy;
   logic          hit;

   assign cell_load = CW'(32'(c_ff.cell_row) * GRID_COLUMNS + 32'(c_ff.cell_col));
   assign cell_cur = CW'(32'(iy_ff) * GRID_COLUMNS + 32'(ix_ff));
   assign memb_addr = MW'(32'(cell_cur) * CELL_CAPACITY + 32'(j_ff));
   assign dx = (fx_rd_ff > c_ff.pos_x) ? fx_rd_ff - c_ff.pos_x : c_ff.pos_x - fx_rd_ff;
   assign dy = (fy_rd_ff > c_ff.pos_y) ? fy_rd_ff - c_ff.pos_y : c_ff.pos_y - fy_rd_ff;
   assign hit = (dx < c_ff.radius) && (dy < c_ff.radius);

   assign cmd_pop = (state_ff == B_IDLE) && cmd_ready;
   assign idle = (state_ff == B_IDLE) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_hit_index = out_idx_ff;
   assign rsp_last = out_last_ff;
   assign rsp_truncated = out_tr_ff;

   // memory ports, registered reads
   always_ff @(posedge clock) begin
      if (state_ff == B_INIT || state_ff == B_CLEAR) fill_mem[sweep_ff] <= 4'd0;
      else if (state_ff == B_LOADWR && fill_rd_ff < 4'(CELL_CAPACITY) && c_ff.load_ok)
         fill_mem[cell_load] <= fill_rd_ff + 4'd1;
      if (state_ff == B_CMD || state_ff == B_LOADRD) fill_rd_ff <= fill_mem[cell_load];
      else fill_rd_ff <= fill_mem[cell_cur];
      if (state_ff == B_LOADWR && fill_rd_ff < 4'(CELL_CAPACITY) && c_ff.load_ok) begin
         memb_mem[MW'(32'(cell_load) * CELL_CAPACITY + 32'(fill_rd_ff))] <=
            c_ff.feature_index;
         fx_mem[FW'(c_ff.feature_index)] <= c_ff.pos_x;
         fy_mem[FW'(c_ff.feature_index)] <= c_ff.pos_y;
      end
      memb_rd_ff <= memb_mem[memb_addr];
      fx_rd_ff <= fx_mem[FW'(memb_rd_ff)];
      fy_rd_ff <= fy_mem[FW'(memb_rd_ff)];
   end

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_INIT;
         sweep_ff <= '0;
         out_v_ff <= 1'b0;
         pend_ff <= 1'b0;
         emitted_ff <= '0;
      end else begin
         out_v_ff <= 1'b0;
         unique case (state_ff)
            B_INIT, B_CLEAR: begin
               sweep_ff <= sweep_ff + CW'(1);
               if (32'(sweep_ff) == NCELL - 1) begin
                  sweep_ff <= '0;
                  if (state_ff == B_CLEAR) begin
                     out_v_ff <= 1'b1; out_kind_ff <= KIND_CLEARED;
                     out_idx_ff <= '0; out_last_ff <= 1'b1; out_tr_ff <= 1'b0;
                  end
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (cmd_ready) begin
                  c_ff <= cmd;
                  state_ff <= B_CMD;
               end
            end
            B_CMD: begin
               if (c_ff.action == ACT_CLEAR) state_ff <= B_CLEAR;
               else if (c_ff.action == ACT_LOAD) state_ff <= B_LOADRD;
               else if (!c_ff.span_ok) state_ff <= B_DONE;
               else begin
                  ix_ff <= c_ff.cx0; iy_ff <= c_ff.cy0;
                  emitted_ff <= '0; over_ff <= 1'b0; pend_ff <= 1'b0;
                  state_ff <= B_CELLRD;
               end
            end
            B_LOADRD: state_ff <= B_LOADWR;
            B_LOADWR: begin
               out_v_ff <= 1'b1;
               out_kind_ff <= (c_ff.load_ok && fill_rd_ff < 4'(CELL_CAPACITY)) ?
                              KIND_LOADED : KIND_DROPPED;
               out_idx_ff <= '0; out_last_ff <= 1'b1; out_tr_ff <= 1'b0;
               state_ff <= B_IDLE;
            end
            B_CELLRD: begin
               j_ff <= '0;
               state_ff <= B_CELL;
            end
            B_CELL: begin
               n_ff <= fill_rd_ff;
               state_ff <= (fill_rd_ff == 4'd0) ? B_NEXT : B_MEMRD;
            end
            B_MEMRD: state_ff <= B_FEAT;
            B_FEAT: begin
               f_ff <= memb_rd_ff;
               state_ff <= B_TEST;
            end
            B_TEST: begin
               if (hit) begin
                  if (32'(emitted_ff) < MAX_HITS) begin
                     // hold one hit back so the final one can carry last
                     if (pend_ff) begin
                        out_v_ff <= 1'b1; out_kind_ff <= KIND_HIT;
                        out_idx_ff <= pend_idx_ff; out_last_ff <= 1'b0;
                        out_tr_ff <= 1'b0;
                     end
                     pend_ff <= 1'b1;
                     pend_idx_ff <= f_ff;
                     emitted_ff <= emitted_ff + HW'(1);
                  end else over_ff <= 1'b1;
               end
               if (32'(j_ff) + 1 < 32'(n_ff) && 32'(j_ff) + 1 < CELL_CAPACITY) begin
                  j_ff <= j_ff + (SW+1)'(1);
                  state_ff <= B_MEMRD;
               end else state_ff <= B_NEXT;
            end
            B_NEXT: begin
               if (iy_ff < c_ff.cy1) begin
                  iy_ff <= iy_ff + 8'd1;
                  state_ff <= B_CELLRD;
               end else if (ix_ff < c_ff.cx1) begin
                  iy_ff <= c_ff.cy0;
                  ix_ff <= ix_ff + 8'd1;
                  state_ff <= B_CELLRD;
               end else state_ff <= B_DONE;
            end
            B_DONE: begin
               out_v_ff <= 1'b1; out_last_ff <= 1'b1;
               if (c_ff.span_ok && pend_ff) begin
                  out_kind_ff <= KIND_HIT; out_idx_ff <= pend_idx_ff;
                  out_tr_ff <= over_ff;
               end else begin
                  out_kind_ff <= KIND_NONE; out_idx_ff <= '0; out_tr_ff <= 1'b0;
               end
               pend_ff <= 1'b0;
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_hit_cap, clock, reset, (32'(emitted_ff) <= MAX_HITS))
   `ASSERT_IMPL(a_tr_last, clock, reset, (out_v_ff && out_tr_ff |-> out_last_ff))
   `ASSERT_IMPL(a_pop_idle, clock, reset, (cmd_pop |=> state_ff == B_CMD))
endmodule
`default_nettype wire

// File: hdl/grid_radius_feature_search.sv
// top level of the grid radius feature search
// depends on grs_pkg, grs_front, grs_queue, grs_back
`default_nettype none
// Usage: a command transfers when start is high and busy is low. action
// selects clear, load or area query. A load or clear answers one result,
// a query answers its hits one per strobe with last on the final one, or
// a single no-hits result.
// Config registers are written through csr_valid/csr_ready; write them only
// while idle, the block does not enforce it. csr_ready is always high.
// Sequencing: the front end captures a clear or load and enqueues it; a
// query passes x products, y products and edges states before enqueue. The
// back end loads through command, read and write states; a clear sweeps the
// grid one cell a cycle (3072 cells at defaults). A query scans every
// covered cell and every stored member of those cells; that scan sets
// throughput. A two entry queue lets the front end take the next command
// while the back end works. After reset a clearing pass of one cell a cycle
// runs in the back end; commands are queued meanwhile. Results cannot be
// stalled: rsp_valid marks each for exactly one cycle.
module grid_radius_feature_search import grs_pkg::*; #(
   parameter int GRID_COLUMNS  = GRID_COLUMNS_DEF,
   parameter int GRID_ROWS     = GRID_ROWS_DEF,
   parameter int MAX_FEATURES  = MAX_FEATURES_DEF,
   parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
   parameter int MAX_HITS      = MAX_HITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [9:0]  req_feature_index,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic [5:0]  req_cell_col,
   input  wire logic [5:0]  req_cell_row,
   input  wire logic [15:0] req_radius,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [9:0]       rsp_hit_index,
   output logic             rsp_last,
   output logic             rsp_truncated,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_data
);
   logic [15:0] min_x_ff, min_y_ff;
   logic [19:0] inv_w_ff, inv_h_ff;
   logic        q_push, q_full, q_empty, q_pop, back_idle;
   cmd_type     q_in, q_out;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= 16'd0;
         min_y_ff <= 16'd0;
         inv_w_ff <= 20'd6554;
         inv_h_ff <= 20'd6554;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_X: min_x_ff <= csr_data[15:0];
            REG_MIN_Y: min_y_ff <= csr_data[15:0];
            REG_INV_W: inv_w_ff <= csr_data;
            REG_INV_H: inv_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   grs_front #(
      .GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS), .MAX_FEATURES(MAX_FEATURES)
   ) u_front (
      .clock, .reset, .start, .busy,
      .req_action, .req_feature_index, .req_pos_x, .req_pos_y,
      .req_cell_col, .req_cell_row, .req_radius,
      .min_x(min_x_ff), .min_y(min_y_ff), .inv_w(inv_w_ff), .inv_h(inv_h_ff),
      .cmd_valid(q_push), .cmd(q_in), .cmd_full(q_full)
   );

   grs_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .empty(q_empty), .pop(q_pop), .pop_data(q_out)
   );

   grs_back #(
      .GRID_COLUMNS(GRID_COLUMNS), .GRID_ROWS(GRID_ROWS),
      .MAX_FEATURES(MAX_FEATURES), .CELL_CAPACITY(CELL_CAPACITY),
      .MAX_HITS(MAX_HITS)
   ) u_back (
      .clock, .reset, .cmd_ready(!q_empty), .cmd(q_out), .cmd_pop(q_pop),
      .idle(back_idle), .rsp_valid, .rsp_kind, .rsp_hit_index, .rsp_last,
      .rsp_truncated
   );

   `ASSERT_IMPL(a_idle_quiet, clock, reset, (back_idle |-> !rsp_valid))
   `ASSERT_IMPL(a_trunc_hit, clock, reset, (rsp_valid && rsp_truncated |-> rsp_kind == KIND_HIT))
   `ASSERT_IMPL(a_idx_zero, clock, reset,
      (rsp_valid && rsp_kind != KIND_HIT |-> rsp_hit_index == 10'd0))
endmodule
`default_nettype wire
